### src/stpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpd_pkg
// Shared constants, register indexes and controller command types.
// ----------------------------------------------------------------------------
package stpd_pkg;

    localparam int SCREEN_COLUMNS = 512;
    localparam int SCREEN_ROWS    = 256;
    localparam int COL_W          = 10;

    localparam logic [2:0] REG_TRIGGER_MODE   = 3'd0;
    localparam logic [2:0] REG_TRIGGER_LEVEL  = 3'd1;
    localparam logic [2:0] REG_HOLDOFF        = 3'd2;
    localparam logic [2:0] REG_INTERNAL_RATE  = 3'd3;
    localparam logic [2:0] REG_COLUMN_STEP    = 3'd4;
    localparam logic [2:0] REG_GAIN           = 3'd5;
    localparam logic [2:0] REG_DC_ENABLE      = 3'd6;
    localparam logic [2:0] REG_DC_COEFFICIENT = 3'd7;

    localparam logic [1:0] MODE_INTERNAL = 2'd0;
    localparam logic [1:0] MODE_RISING   = 2'd1;
    localparam logic [1:0] MODE_FALLING  = 2'd2;
    localparam logic [1:0] MODE_FREE     = 2'd3;

    localparam logic [31:0] ONE_Q824 = 32'h0100_0000;
    localparam logic [13:0] HOLD_MAX = 14'h3FFF;

    typedef struct packed {
        logic load;   // latch sample, start DC multiply
        logic dc;     // finish DC blocker, start gain multiply
        logic gain;   // finish level
        logic commit; // trigger, extremes, column, build result
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_status;

    function automatic logic [7:0] to_row(input logic signed [15:0] level);
        logic signed [31:0] t;
        logic signed [31:0] y;
        begin
            t = 32'(signed'(SCREEN_ROWS - 2)) * 32'sd32768
                - 32'(level) * 32'(signed'(SCREEN_ROWS));
            y = t / 32'sd65536;
            if (y < 0) begin
                y = 0;
            end
            if (y > SCREEN_ROWS - 1) begin
                y = SCREEN_ROWS - 1;
            end
            to_row = y[7:0];
        end
    endfunction

endpackage

### src/stpd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpd_ctrl
// Sequencer: steps one sample through load, DC, gain and commit.
// ----------------------------------------------------------------------------
module stpd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  stpd_pkg::t_status i_status,
    output stpd_pkg::t_cmd    o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DC   = 2'd1;
    localparam logic [1:0] S_GAIN = 2'd2;
    localparam logic [1:0] S_COMM = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DC;
                end
            end
            S_DC: begin
                o_cmd.dc = 1'b1;
                n_state  = S_GAIN;
            end
            S_GAIN: begin
                o_cmd.gain = 1'b1;
                n_state    = S_COMM;
            end
            S_COMM: begin
                if (!i_status.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### src/stpd_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpd_dp
// Datapath: DC blocker, gain, trigger, extremes, column stepping, output.
// ----------------------------------------------------------------------------
module stpd_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [31:0]       i_cfg_data,
    input  logic [15:0]       i_sample,
    input  stpd_pkg::t_cmd    i_cmd,
    output stpd_pkg::t_status o_status,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [39:0]       o_data
);

    logic [1:0]         r_mode;
    logic signed [15:0] r_tlevel;
    logic [13:0]        r_holdoff;
    logic [23:0]        r_rate;
    logic [28:0]        r_step;
    logic [25:0]        r_gain;
    logic               r_dc_en;
    logic [15:0]        r_coef;

    logic signed [31:0] r_dc_out;
    logic signed [15:0] r_prev_raw;
    logic signed [15:0] r_prev_level;
    logic [31:0]        r_phase;
    logic [13:0]        r_hold_cnt;
    logic [stpd_pkg::COL_W-1:0] r_col_idx;
    logic [31:0]        r_col_acc;
    logic signed [15:0] r_max;
    logic signed [15:0] r_min;
    logic               r_empty;
    logic               r_max_last;

    logic signed [15:0] r_raw;
    logic signed [48:0] r_dc_prod;
    logic signed [58:0] r_g_prod;
    logic signed [15:0] r_level;

    logic               r_out_valid;
    logic [39:0]        r_out_data;

    logic signed [48:0] dc_q;
    logic signed [34:0] dc_sum;
    logic signed [31:0] dc_sat;
    logic signed [31:0] v_sel;
    logic signed [58:0] g_q;
    logic signed [15:0] lvl_sat;

    logic [32:0] ph_sum;
    logic        trig;
    logic [13:0] hold_inc;
    logic [stpd_pkg::COL_W-1:0] col_base;
    logic [31:0] acc_base;
    logic        empty_base;
    logic signed [15:0] mx;
    logic signed [15:0] mn;
    logic        mlast;
    logic [32:0] acc_sum;
    logic [31:0] acc_new;
    logic        col;
    logic [7:0]  ymax;
    logic [7:0]  ymin;

    assign o_status.out_busy = r_out_valid && !i_ready;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    always_comb begin
        dc_q   = r_dc_prod / 49'sd65536;
        dc_sum = 35'((35'(r_raw) - 35'(r_prev_raw)) * 35'sd256) + 35'(dc_q);
        if (dc_sum > 35'sh7FFF_FFFF) begin
            dc_sat = 32'sh7FFF_FFFF;
        end else if (dc_sum < -35'sh8000_0000) begin
            dc_sat = -32'sh8000_0000;
        end else begin
            dc_sat = dc_sum[31:0];
        end
        v_sel = r_dc_en ? dc_sat : 32'(r_raw) * 32'sd256;

        g_q = r_g_prod / 59'sd16777216;
        if (g_q > 59'sd32767) begin
            lvl_sat = 16'sh7FFF;
        end else if (g_q < -59'sd32768) begin
            lvl_sat = -16'sh8000;
        end else begin
            lvl_sat = g_q[15:0];
        end
    end

    always_comb begin
        ph_sum = {1'b0, r_phase} + {9'd0, r_rate};
        case (r_mode)
            stpd_pkg::MODE_INTERNAL: trig = ph_sum[32];
            stpd_pkg::MODE_RISING:
                trig = (r_level >= r_tlevel) && (r_prev_level < r_tlevel);
            stpd_pkg::MODE_FALLING:
                trig = (r_level <= r_tlevel) && (r_prev_level > r_tlevel);
            default:
                trig = (r_col_idx >= stpd_pkg::COL_W'(stpd_pkg::SCREEN_COLUMNS));
        endcase
        hold_inc = (r_hold_cnt < stpd_pkg::HOLD_MAX) ? r_hold_cnt + 14'd1 : r_hold_cnt;
        if (trig && (r_mode == stpd_pkg::MODE_RISING || r_mode == stpd_pkg::MODE_FALLING)
            && hold_inc < r_holdoff) begin
            trig = 1'b0;
        end
        col_base   = trig ? '0 : r_col_idx;
        acc_base   = trig ? stpd_pkg::ONE_Q824 : r_col_acc;
        empty_base = trig ? 1'b1 : r_empty;

        mx    = r_max;
        mn    = r_min;
        mlast = r_max_last;
        if (empty_base || r_level > r_max) begin
            mx    = r_level;
            mlast = 1'b1;
        end
        if (empty_base || r_level < r_min) begin
            mn    = r_level;
            mlast = 1'b0;
        end

        acc_sum = {1'b0, acc_base} + {4'd0, r_step};
        acc_new = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
        col  = (acc_new >= stpd_pkg::ONE_Q824)
               && (col_base < stpd_pkg::COL_W'(stpd_pkg::SCREEN_COLUMNS));
        ymax = stpd_pkg::to_row(mx);
        ymin = stpd_pkg::to_row(mn);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= stpd_pkg::MODE_INTERNAL;
            r_tlevel     <= '0;
            r_holdoff    <= 14'd100;
            r_rate       <= 24'd763763;
            r_step       <= 29'd94346;
            r_gain       <= 26'd65536;
            r_dc_en      <= 1'b0;
            r_coef       <= 16'd65164;
            r_dc_out     <= '0;
            r_prev_raw   <= '0;
            r_prev_level <= '0;
            r_phase      <= '0;
            r_hold_cnt   <= '0;
            r_col_idx    <= '0;
            r_col_acc    <= stpd_pkg::ONE_Q824;
            r_empty      <= 1'b1;
            r_max_last   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    stpd_pkg::REG_TRIGGER_MODE:   r_mode    <= i_cfg_data[1:0];
                    stpd_pkg::REG_TRIGGER_LEVEL:  r_tlevel  <= i_cfg_data[15:0];
                    stpd_pkg::REG_HOLDOFF:        r_holdoff <= i_cfg_data[13:0];
                    stpd_pkg::REG_INTERNAL_RATE:  r_rate    <= i_cfg_data[23:0];
                    stpd_pkg::REG_COLUMN_STEP:    r_step    <= i_cfg_data[28:0];
                    stpd_pkg::REG_GAIN:           r_gain    <= i_cfg_data[25:0];
                    stpd_pkg::REG_DC_ENABLE:      r_dc_en   <= i_cfg_data[0];
                    stpd_pkg::REG_DC_COEFFICIENT: r_coef    <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.dc) begin
                r_dc_out   <= dc_sat;
                r_prev_raw <= r_raw;
            end
            if (i_cmd.commit) begin
                if (r_mode == stpd_pkg::MODE_INTERNAL) begin
                    r_phase <= ph_sum[31:0];
                end
                r_hold_cnt   <= trig ? '0 : hold_inc;
                r_prev_level <= r_level;
                r_max_last   <= mlast;
                if (acc_new >= stpd_pkg::ONE_Q824) begin
                    r_col_acc <= acc_new - stpd_pkg::ONE_Q824;
                    r_empty   <= 1'b1;
                end else begin
                    r_col_acc <= acc_new;
                    r_empty   <= 1'b0;
                end
                r_col_idx <= col ? col_base + 1'b1 : col_base;
                if (trig || col) begin
                    r_out_valid <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_raw     <= i_sample;
            r_dc_prod <= 49'(signed'({1'b0, r_coef})) * 49'(r_dc_out);
        end
        if (i_cmd.dc) begin
            r_g_prod <= 59'(v_sel) * 59'(signed'({1'b0, r_gain}));
        end
        if (i_cmd.gain) begin
            r_level <= lvl_sat;
        end
        if (i_cmd.commit) begin
            r_max <= mx;
            r_min <= mn;
            r_out_data <= {3'd0,
                           col ? (mlast ? ymax : ymin) : 8'd0,
                           col ? (mlast ? ymin : ymax) : 8'd0,
                           col ? col_base[8:0] : 9'd0,
                           col,
                           trig ? r_col_idx : 10'd0,
                           trig};
        end
    end

endmodule

### src/scope_trigger_peak_decimator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scope_trigger_peak_decimator_top
// Scope trigger with per-column min/max peak decimation.
// ----------------------------------------------------------------------------
// channel   direction  contents
// s_axis    in         sample
// m_axis    out        frame_end, frame_columns, column_valid, column, y rows
// cfg       in         register index and value
// A sample steps through load and DC multiply, gain multiply, saturate,
// commit. Results sit in an output register; commit waits while it is full and not taken.
// Reset restores register defaults and clears control state; pipeline and peak registers are not reset.
// ----------------------------------------------------------------------------
module scope_trigger_peak_decimator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [15:0] sample
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] frame_end, [10:1] frame_columns, [11] column_valid, [20:12] column,
    // [28:21] y_first, [36:29] y_second
    output logic [39:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    stpd_pkg::t_cmd    cmd;
    stpd_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    stpd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    stpd_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_idx  (i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_sample   (s_axis_tdata),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_data     (m_axis_tdata)
    );

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.dc, cmd.gain, cmd.commit})) else $error("cmd overlap");
    a_load_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |=> cmd.dc) else $error("dc missed");
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> !(m_axis_tvalid && !m_axis_tready)) else $error("result dropped");

endmodule

### bench/tb_scope_trigger_peak_decimator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_scope_trigger_peak_decimator_top
// Self-checking bench for the scope trigger and min/max peak decimator.
// Samples are queued per phase, driven with random gaps, and predicted in
// order; every result on m_axis is checked field by field against the oldest
// prediction. Phases cover all trigger modes, gain and DC blocker settings
// and column step extremes, with a long output stall and a drain pause.
// ----------------------------------------------------------------------------
module tb_scope_trigger_peak_decimator_top;

    localparam int WATCHDOG = 20000;

    typedef struct packed {
        logic [9:0] frame_columns;
        logic       frame_end;
        logic       column_valid;
        logic [8:0] column;
        logic [7:0] y_first;
        logic [7:0] y_second;
    } t_column_pair;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    scope_trigger_peak_decimator_top uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // settings mirror
    logic [1:0]         trig_mode;
    logic signed [15:0] trig_level;
    logic [13:0]        holdoff_len;
    logic [23:0]        phase_rate;
    logic [28:0]        col_step;
    logic [25:0]        gain_q;
    logic               dc_on;
    logic [15:0]        dc_pole;
    // predictor state
    logic signed [31:0] dc_acc;
    logic signed [15:0] last_raw, last_level, peak_max, peak_min;
    logic [31:0]        phase_acc, col_acc;
    logic [13:0]        hold_cnt;
    logic [9:0]         col_idx;
    logic               col_empty, max_last;

    logic [15:0]  pending_samples[$];
    t_column_pair expected_pairs[$];
    int errors = 0, accepted = 0, delivered = 0, idle_cycles = 0;
    bit send_gaps = 1, recv_gaps = 1, stall_out = 0;
    int send_gap = 0, recv_gap = 0;

    task automatic report_mismatch(input string what, input logic [39:0] got,
                                   input logic [39:0] want);
        $display("mismatch %s: got %h want %h (result %0d)", what, got, want, delivered);
        errors++;
    endtask

    function automatic logic [7:0] level_row(input logic signed [15:0] lv);
        longint t;
        t = longint'(stpd_pkg::SCREEN_ROWS - 2) * 32768
            - longint'(lv) * stpd_pkg::SCREEN_ROWS;
        t = t / 65536;
        if (t < 0) t = 0;
        if (t > stpd_pkg::SCREEN_ROWS - 1) t = stpd_pkg::SCREEN_ROWS - 1;
        return t[7:0];
    endfunction

    task automatic reset_predictor();
        trig_mode = stpd_pkg::MODE_INTERNAL; trig_level = 0; holdoff_len = 100;
        phase_rate = 763763; col_step = 94346; gain_q = 65536;
        dc_on = 0; dc_pole = 65164;
        dc_acc = 0; last_raw = 0; last_level = 0; phase_acc = 0; hold_cnt = 0;
        col_idx = 0; col_acc = stpd_pkg::ONE_Q824; peak_max = 0; peak_min = 0;
        col_empty = 1; max_last = 0;
    endtask

    task automatic add_sample(input logic [15:0] s);
        pending_samples = {pending_samples, s};
    endtask

    task automatic predict_sample(input logic signed [15:0] raw);
        longint acc, v, lv;
        logic [32:0] np;
        logic signed [15:0] level;
        bit trig;
        t_column_pair r;
        r = '0;
        acc = (longint'(raw) - longint'(last_raw)) * 256;
        acc += (longint'(dc_pole) * longint'(dc_acc)) / 65536;
        if (acc > 64'sd2147483647) acc = 64'sd2147483647;
        if (acc < -64'sd2147483648) acc = -64'sd2147483648;
        dc_acc = acc[31:0];
        last_raw = raw;
        v = dc_on ? longint'(dc_acc) : longint'(raw) * 256;
        lv = (v * longint'(gain_q)) / 64'sd16777216;
        if (lv > 32767) lv = 32767;
        if (lv < -32768) lv = -32768;
        level = lv[15:0];
        case (trig_mode)
            stpd_pkg::MODE_INTERNAL: begin
                np = {1'b0, phase_acc} + phase_rate;
                trig = np[32];
                phase_acc = np[31:0];
            end
            stpd_pkg::MODE_RISING: trig = level >= trig_level && last_level < trig_level;
            stpd_pkg::MODE_FALLING: trig = level <= trig_level && last_level > trig_level;
            default: trig = col_idx >= stpd_pkg::SCREEN_COLUMNS;
        endcase
        if (hold_cnt < stpd_pkg::HOLD_MAX) hold_cnt++;
        if (trig && (trig_mode == stpd_pkg::MODE_RISING
                     || trig_mode == stpd_pkg::MODE_FALLING)
            && hold_cnt < holdoff_len) trig = 0;
        if (trig) begin
            r.frame_end = 1; r.frame_columns = col_idx;
            col_idx = 0; col_acc = stpd_pkg::ONE_Q824; col_empty = 1; hold_cnt = 0;
        end
        if (col_empty || level > peak_max) begin peak_max = level; max_last = 1; end
        if (col_empty || level < peak_min) begin peak_min = level; max_last = 0; end
        col_empty = 0;
        if (col_acc > 32'hFFFF_FFFF - col_step) col_acc = 32'hFFFF_FFFF;
        else col_acc += col_step;
        if (col_acc >= stpd_pkg::ONE_Q824) begin
            if (col_idx < stpd_pkg::SCREEN_COLUMNS) begin
                r.column_valid = 1; r.column = col_idx[8:0];
                r.y_first  = max_last ? level_row(peak_min) : level_row(peak_max);
                r.y_second = max_last ? level_row(peak_max) : level_row(peak_min);
                col_idx++;
            end
            col_empty = 1;
            col_acc -= stpd_pkg::ONE_Q824;
        end
        last_level = level;
        if (r.frame_end || r.column_valid) expected_pairs = {expected_pairs, r};
    endtask

    // driver: predict at acceptance
    always @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            predict_sample(s_axis_tdata);
            void'(pending_samples.pop_front());
            accepted++;
        end
        if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            s_axis_tvalid <= 1'b0;
        end else if ((s_axis_tvalid && s_axis_tready) || !s_axis_tvalid) begin
            if (send_gaps && $urandom_range(0, 9) == 0) begin
                send_gap <= $urandom_range(1, 18);
                s_axis_tvalid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= pending_samples[0];
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_column_pair got, want;
        if (m_axis_tvalid && m_axis_tready) begin
            got.frame_end = m_axis_tdata[0];
            got.frame_columns = m_axis_tdata[10:1];
            got.column_valid = m_axis_tdata[11];
            got.column = m_axis_tdata[20:12];
            got.y_first = m_axis_tdata[28:21];
            got.y_second = m_axis_tdata[36:29];
            delivered++;
            if (expected_pairs.size() == 0) begin
                report_mismatch("unexpected result", m_axis_tdata, '0);
            end else begin
                want = expected_pairs.pop_front();
                if (got.frame_end != want.frame_end)
                    report_mismatch("frame_end", got.frame_end, want.frame_end);
                if (got.frame_columns != want.frame_columns)
                    report_mismatch("frame_columns", got.frame_columns, want.frame_columns);
                if (got.column_valid != want.column_valid)
                    report_mismatch("column_valid", got.column_valid, want.column_valid);
                if (got.column != want.column)
                    report_mismatch("column", got.column, want.column);
                if (got.y_first != want.y_first)
                    report_mismatch("y_first", got.y_first, want.y_first);
                if (got.y_second != want.y_second)
                    report_mismatch("y_second", got.y_second, want.y_second);
            end
        end
        if (stall_out) begin
            m_axis_tready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            m_axis_tready <= 1'b0;
        end else if (recv_gaps && $urandom_range(0, 9) == 0) begin
            recv_gap <= $urandom_range(1, 18);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready) || stall_out || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG) begin
            $display("watchdog: no progress");
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1; i_cfg_index <= idx; i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            stpd_pkg::REG_TRIGGER_MODE:   trig_mode = val[1:0];
            stpd_pkg::REG_TRIGGER_LEVEL:  trig_level = val[15:0];
            stpd_pkg::REG_HOLDOFF:        holdoff_len = val[13:0];
            stpd_pkg::REG_INTERNAL_RATE:  phase_rate = val[23:0];
            stpd_pkg::REG_COLUMN_STEP:    col_step = val[28:0];
            stpd_pkg::REG_GAIN:           gain_q = val[25:0];
            stpd_pkg::REG_DC_ENABLE:      dc_on = val[0];
            default:                      dc_pole = val[15:0];
        endcase
    endtask

    task automatic drain();
        while (pending_samples.size() > 0 || expected_pairs.size() > 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic queue_random(input int n, input int style);
        int ph;
        ph = $urandom_range(0, 3);
        repeat (n) begin
            case (style)
                0: add_sample(16'($urandom));
                default: begin
                    // sine-ish triangle wave crossing the level, with noise
                    ph = (ph + $urandom_range(1, 3)) % 64;
                    add_sample(16'((ph < 32 ? ph : 64 - ph) * 1800 - 28000
                                   + $urandom_range(0, 511)));
                end
            endcase
        end
    endtask

    initial begin
        logic [15:0] edge_vals[12];
        reset_predictor();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        edge_vals = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h8000,
                      16'h7FFF, 16'h5555, 16'hAAAA, 16'h7FFF, 16'h8000, 16'h0000};
        // directed extremes with a half column step, one column per two samples
        write_reg(stpd_pkg::REG_COLUMN_STEP, 32'h0080_0000);
        foreach (edge_vals[i]) add_sample(edge_vals[i]);
        drain();
        // rising edge, holdoff of 1, gain of 1000 (clip both ways)
        write_reg(stpd_pkg::REG_TRIGGER_MODE, stpd_pkg::MODE_RISING);
        write_reg(stpd_pkg::REG_HOLDOFF, 1);
        write_reg(stpd_pkg::REG_GAIN, 65536000);
        write_reg(stpd_pkg::REG_TRIGGER_LEVEL, 0);
        foreach (edge_vals[i]) add_sample(edge_vals[i]);
        drain();
        // falling edge, large step (saturating accumulator), small gain
        write_reg(stpd_pkg::REG_TRIGGER_MODE, stpd_pkg::MODE_FALLING);
        write_reg(stpd_pkg::REG_COLUMN_STEP, 536870911);
        write_reg(stpd_pkg::REG_GAIN, 65);
        write_reg(stpd_pkg::REG_TRIGGER_LEVEL, 32'hFFFF_8000);
        queue_random(150, 1);
        drain();
        // free run with unit step: overflow past the last column
        write_reg(stpd_pkg::REG_TRIGGER_MODE, stpd_pkg::MODE_FREE);
        write_reg(stpd_pkg::REG_COLUMN_STEP, 1 << 24);
        write_reg(stpd_pkg::REG_GAIN, 65536);
        queue_random(300, 1);
        send_gaps = 0;
        drain();
        send_gaps = 1;
        // long output stall while input keeps coming, one column per sample
        fork
            begin
                stall_out = 1;
                repeat (200) @(posedge i_clk);
                stall_out = 0;
            end
        join_none
        queue_random(200, 0);
        drain();
        // internal trigger, fast rate, DC blocker with extremes of the pole
        write_reg(stpd_pkg::REG_TRIGGER_MODE, stpd_pkg::MODE_INTERNAL);
        write_reg(stpd_pkg::REG_INTERNAL_RATE, 16777215);
        write_reg(stpd_pkg::REG_COLUMN_STEP, 32'h0040_0000);
        write_reg(stpd_pkg::REG_DC_ENABLE, 1);
        write_reg(stpd_pkg::REG_DC_COEFFICIENT, 65535);
        queue_random(150, 0);
        drain();
        write_reg(stpd_pkg::REG_DC_COEFFICIENT, 0);
        write_reg(stpd_pkg::REG_INTERNAL_RATE, 1);
        queue_random(100, 1);
        drain();
        // rising edge with holdoff and a positive level, DC blocker off
        write_reg(stpd_pkg::REG_DC_ENABLE, 0);
        write_reg(stpd_pkg::REG_DC_COEFFICIENT, 65164);
        write_reg(stpd_pkg::REG_TRIGGER_MODE, stpd_pkg::MODE_RISING);
        write_reg(stpd_pkg::REG_HOLDOFF, 10000);
        write_reg(stpd_pkg::REG_TRIGGER_LEVEL, 32'h0000_1000);
        write_reg(stpd_pkg::REG_COLUMN_STEP, 32'h0030_0000);
        queue_random(200, 1);
        drain();
        write_reg(stpd_pkg::REG_HOLDOFF, 20);
        write_reg(stpd_pkg::REG_GAIN, 200000);
        queue_random(200, 1);
        drain();
        // last part with no idling
        send_gaps = 0;
        recv_gaps = 0;
        write_reg(stpd_pkg::REG_TRIGGER_MODE, stpd_pkg::MODE_FALLING);
        write_reg(stpd_pkg::REG_TRIGGER_LEVEL, 32'hFFFF_F000);
        queue_random(200, 1);
        drain();
        $display("covered %0d samples and %0d results over all trigger modes,", accepted,
                 delivered);
        $display("gain and column step extremes, DC blocker on and off");
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
